FILE: design/tlfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged length frame deframer package
// Shared constants, register indexes and the status and result records.
// ----------------------------------------------------------------------------
package tlfd_pkg;

  localparam int HDR_BYTES  = 6;
  localparam int WIN_DEPTH  = HDR_BYTES - 1;
  localparam int FILL_W     = $clog2(WIN_DEPTH + 1);
  localparam int BYTE_W     = 8;
  localparam int TAG_W      = 32;
  localparam int LEN_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [LEN_W-1:0] MAX_BODY_LEN_RESET = LEN_W'(4094);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAG_PATTERN  = 2'd0,
    CFG_MAX_BODY_LEN = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic             header_ok;
    logic             bad_header;
    logic [LEN_W-1:0] length;
  } hunt_status_t;

  typedef struct packed {
    logic              body_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              body_last;
    logic              header_ok;
    logic [LEN_W-1:0]  frame_length;
    logic              bad_header;
  } tlfd_result_t;

endpackage

FILE: design/tlfd_hunter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header hunter
// Sliding five byte window that checks each new byte against the tag and
// the length limit, and drops the oldest byte when a full window fails.
// ----------------------------------------------------------------------------
module tlfd_hunter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [tlfd_pkg::BYTE_W-1:0]  in_byte,
  input  logic [tlfd_pkg::TAG_W-1:0]   tag_pattern,
  input  logic [tlfd_pkg::LEN_W-1:0]   max_body_len,
  output tlfd_pkg::hunt_status_t       status
);
  import tlfd_pkg::*;

  logic [BYTE_W-1:0] window [WIN_DEPTH];
  logic [FILL_W-1:0] fill;
  logic              full;
  logic [TAG_W-1:0]  cand_tag;
  logic [LEN_W-1:0]  cand_len;
  logic              good;

  assign full     = (fill == FILL_W'(WIN_DEPTH));
  assign cand_tag = {window[0], window[1], window[2], window[3]};
  assign cand_len = {window[4], in_byte};
  assign good     = full && (cand_tag == tag_pattern) && (cand_len != '0)
                    && (cand_len <= max_body_len);

  always_comb begin
    status.header_ok  = good;
    status.bad_header = full && !good;
    status.length     = good ? cand_len : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (step) begin
      if (!full) begin
        fill <= fill + FILL_W'(1);
      end else if (good) begin
        fill <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (!full) begin
        window[fill] <= in_byte;
      end else if (!good) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          window[i] <= window[i+1];
        end
        window[WIN_DEPTH-1] <= in_byte;
      end
    end
  end

  hunter_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WIN_DEPTH))
    else $error("Window fill exceeds the window depth.");

  hunter_rearm: assert property (@(posedge clk) disable iff (rst)
    (step && good) |=> (fill == '0))
    else $error("Window did not empty after a good header.");

endmodule

FILE: design/tlfd_body.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Body counter
// Passes the announced number of body bytes, marks the last one, and
// assembles the result word for every accepted byte.
// ----------------------------------------------------------------------------
module tlfd_body (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [tlfd_pkg::BYTE_W-1:0]  in_byte,
  input  tlfd_pkg::hunt_status_t       status,
  output logic                         in_body,
  output tlfd_pkg::tlfd_result_t       result
);
  import tlfd_pkg::*;

  logic [LEN_W-1:0] body_total;
  logic [LEN_W-1:0] body_count;
  logic [LEN_W-1:0] body_count_next;
  logic             last;

  assign body_count_next = body_count + LEN_W'(1);
  assign last            = in_body && (body_count_next == body_total);

  always_comb begin
    result.body_valid   = in_body;
    result.out_byte     = in_body ? in_byte : '0;
    result.body_last    = last;
    result.header_ok    = !in_body && status.header_ok;
    result.bad_header   = !in_body && status.bad_header;
    result.frame_length = in_body ? body_total : status.length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body    <= 1'b0;
      body_total <= '0;
      body_count <= '0;
    end else if (accept) begin
      if (in_body) begin
        if (last) begin
          in_body    <= 1'b0;
          body_total <= '0;
          body_count <= '0;
        end else begin
          body_count <= body_count_next;
        end
      end else if (status.header_ok) begin
        in_body    <= 1'b1;
        body_total <= status.length;
        body_count <= '0;
      end
    end
  end

  body_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_body |-> (body_count < body_total))
    else $error("Body count reached the frame length while still in the body.");

endmodule

FILE: design/tagged_length_frame_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged length frame deframer
// Hunts a byte stream for a tag and length header and passes the frame body.
// ----------------------------------------------------------------------------
// One stream byte enters per word on the in channel. Every accepted word
// yields exactly one result word on the out channel: a body byte with its
// last mark, a header_ok flag with the new frame length, a bad_header flag
// when a six byte header candidate fails, or an all zero word while the window
// fills. The header is a four byte tag equal to the tag pattern register
// followed by a big-endian length in 1 to max_body_len.
// A valid result appears in the cycle after acceptance. One word is taken
// every cycle while the receiver takes results, as the window compare and
// the body counter are combinational ahead of the result register, which
// lets a new word in when it is empty or its result is taken in the same
// cycle, so a stalled receiver stops the input after one held result.
// Configuration writes use the cfg channel, which is always ready; index 0
// is the tag pattern and index 1 is max_body_len, other indexes are ignored.
// Reset empties the window and the body counter, drops any held result, and
// sets the tag pattern to zero and max_body_len to 4094.
// ----------------------------------------------------------------------------
module tagged_length_frame_deframer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tlfd_pkg::BYTE_W-1:0]     in_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            body_valid,
  output logic [tlfd_pkg::BYTE_W-1:0]     out_byte,
  output logic                            body_last,
  output logic                            header_ok,
  output logic [tlfd_pkg::LEN_W-1:0]      frame_length,
  output logic                            bad_header,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tlfd_pkg::*;

  logic             accept;
  logic             in_body;
  logic [TAG_W-1:0] tag_pattern;
  logic [LEN_W-1:0] max_body_len;
  hunt_status_t     status;
  tlfd_result_t     result;
  tlfd_result_t     held;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_pattern  <= '0;
      max_body_len <= MAX_BODY_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TAG_PATTERN:  tag_pattern  <= cfg_data[TAG_W-1:0];
        CFG_MAX_BODY_LEN: max_body_len <= cfg_data[LEN_W-1:0];
        default:          ;
      endcase
    end
  end

  tlfd_hunter u_hunter (
    .clk          (clk),
    .rst          (rst),
    .step         (accept && !in_body),
    .in_byte      (in_byte),
    .tag_pattern  (tag_pattern),
    .max_body_len (max_body_len),
    .status       (status)
  );

  tlfd_body u_body (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .status  (status),
    .in_body (in_body),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= result;
    end
  end

  assign body_valid   = held.body_valid;
  assign out_byte     = held.out_byte;
  assign body_last    = held.body_last;
  assign header_ok    = held.header_ok;
  assign frame_length = held.frame_length;
  assign bad_header   = held.bad_header;

  accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("An accepted word produced no result word.");

  last_inside_body: assert property (@(posedge clk) disable iff (rst)
    (out_valid && body_last) |-> body_valid)
    else $error("Last mark on a word that is not a body byte.");

  flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones({body_valid, header_ok, bad_header}) <= 1))
    else $error("More than one kind of result in one word.");

  header_opens_body: assert property (@(posedge clk) disable iff (rst)
    (accept && result.header_ok) |=> in_body)
    else $error("A good header did not open a frame body.");

endmodule

FILE: sim/tagged_length_frame_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged length frame deframer testbench
// Drives byte words into the deframer and predicts every result word with its
// own header hunt and body counter. Directed tests cover window fill, zero and
// oversized lengths, sliding recovery and register extremes. Random frames
// then run under several idle and stall mixes, a long receiver hold-off, and
// the opening of a frame of the largest length.
// ----------------------------------------------------------------------------
module tagged_length_frame_deframer_core_tb;
  import tlfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RX_HOLD_LEN = 300;
  localparam int PHASE_WORDS = 240;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [BYTE_W-1:0] in_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic body_valid;
  logic [BYTE_W-1:0] out_byte;
  logic body_last;
  logic header_ok;
  logic [LEN_W-1:0] frame_length;
  logic bad_header;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted deframer state and registers.
  logic [BYTE_W-1:0] hunt_win [WIN_DEPTH];
  int hunt_fill;
  logic frame_active;
  logic [LEN_W-1:0] frame_size;
  logic [LEN_W-1:0] frame_seen;
  logic [TAG_W-1:0] tag_reg;
  logic [LEN_W-1:0] max_len_reg;

  tlfd_result_t pending_results[$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  int hold_cycles = 0;
  int words_sent = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  logic rx_hold_on = 1'b0;
  logic [TAG_W-1:0] cur_tag = '0;
  logic [LEN_W-1:0] cur_max = MAX_BODY_LEN_RESET;

  tagged_length_frame_deframer_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .body_valid(body_valid),
    .out_byte(out_byte),
    .body_last(body_last),
    .header_ok(header_ok),
    .frame_length(frame_length),
    .bad_header(bad_header),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_hunt();
    for (int i = 0; i < WIN_DEPTH; i++) hunt_win[i] = '0;
    hunt_fill = 0;
    frame_active = 1'b0;
    frame_size = '0;
    frame_seen = '0;
  endfunction

  function automatic tlfd_result_t predict_deframe(input logic [BYTE_W-1:0] b);
    tlfd_result_t r;
    logic [TAG_W-1:0] cand_tag;
    logic [LEN_W-1:0] cand_len;
    r = '0;
    if (frame_active) begin
      frame_seen = frame_seen + 16'd1;
      r.body_valid = 1'b1;
      r.out_byte = b;
      r.frame_length = frame_size;
      if (frame_seen == frame_size) begin
        r.body_last = 1'b1;
        clear_hunt();
      end
    end else if (hunt_fill < WIN_DEPTH) begin
      hunt_win[hunt_fill] = b;
      hunt_fill++;
    end else begin
      cand_tag = {hunt_win[0], hunt_win[1], hunt_win[2], hunt_win[3]};
      cand_len = {hunt_win[4], b};
      if (cand_tag == tag_reg && cand_len != '0 && cand_len <= max_len_reg) begin
        r.header_ok = 1'b1;
        r.frame_length = cand_len;
        clear_hunt();
        frame_active = 1'b1;
        frame_size = cand_len;
      end else begin
        r.bad_header = 1'b1;
        for (int i = 0; i < WIN_DEPTH - 1; i++) hunt_win[i] = hunt_win[i + 1];
        hunt_win[WIN_DEPTH - 1] = b;
      end
    end
    return r;
  endfunction

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    tlfd_result_t want;
    if (rst) begin
      clear_hunt();
      tag_reg = '0;
      max_len_reg = MAX_BODY_LEN_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result word with no expectation, expected none, actual %0h",
                   $time, {body_valid, out_byte, body_last, header_ok, frame_length,
                           bad_header});
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("body_valid", 32'(want.body_valid), 32'(body_valid));
          compare_field("out_byte", 32'(want.out_byte), 32'(out_byte));
          compare_field("body_last", 32'(want.body_last), 32'(body_last));
          compare_field("header_ok", 32'(want.header_ok), 32'(header_ok));
          compare_field("frame_length", 32'(want.frame_length), 32'(frame_length));
          compare_field("bad_header", 32'(want.bad_header), 32'(bad_header));
        end
      end
      if (in_valid && in_ready) pending_results.push_back(predict_deframe(in_byte));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TAG_PATTERN: begin
            tag_reg = cfg_data[TAG_W-1:0];
          end
          CFG_MAX_BODY_LEN: begin
            max_len_reg = cfg_data[LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
    end else if (rx_hold_on) begin
      out_ready <= (hold_cycles >= RX_HOLD_LEN);
      if (hold_cycles < RX_HOLD_LEN) hold_cycles <= hold_cycles + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
      hold_cycles <= 0;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_header(input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len);
    for (int i = 3; i >= 0; i--) send_byte(tag[8*i +: 8]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic send_frame(input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len);
    send_header(tag, len);
    repeat (len) send_byte(8'($urandom_range(255)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [TAG_W-1:0] tag, input logic [CFG_DATA_W-1:0] max_word);
    write_reg(CFG_TAG_PATTERN, tag);
    write_reg(CFG_MAX_BODY_LEN, max_word);
    cur_tag = tag;
    cur_max = max_word[LEN_W-1:0];
  endtask

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned cap;
    int unsigned len;
    int unsigned k;
    logic [TAG_W-1:0] tag;
    kind = $urandom_range(99);
    tag = cur_tag;
    cap = ($urandom_range(9) == 0) ? 64 : 16;
    if (cap > 32'(cur_max)) cap = 32'(cur_max);
    len = (cap == 0) ? 1 : $urandom_range(cap, 1);
    if (kind < 70) begin
      repeat ($urandom_range(6)) send_byte(8'($urandom_range(255)));
      send_frame(tag, LEN_W'(len));
    end else if (kind < 80) begin
      k = $urandom_range(TAG_W - 1);
      tag[k] = ~tag[k];
      send_header(tag, LEN_W'(len));
    end else if (kind < 90) begin
      if (cur_max == 16'hFFFF || $urandom_range(1) == 0) len = 0;
      else len = $urandom_range(65535, 32'(cur_max) + 1);
      send_header(tag, LEN_W'(len));
    end else begin
      k = $urandom_range(3);
      for (int i = 0; i < k; i++) send_byte(tag[8*(3-i) +: 8]);
      repeat ($urandom_range(10, 1)) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_hunt_basics();
    tx_gap_pct = 0;
    repeat (6) send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_header('0, 16'd4095);
    send_frame('0, 16'd2);
  endtask

  task automatic test_register_extremes();
    set_config(32'hFFFF_FFFF, 32'h0000_0001);
    write_reg(CFG_UNUSED_IDX, 32'h0);
    send_frame(32'hFFFF_FFFF, 16'd1);
    send_header(32'hFFFF_FFFF, 16'd2);
    set_config(32'hFFFF_FFFF, 32'h0000_0000);
    send_header(32'hFFFF_FFFF, 16'd1);
    set_config($urandom(), {16'($urandom()), 16'hFFFE});
    send_header(cur_tag, 16'hFFFF);
  endtask

  task automatic test_random_frames();
    int tx_pcts [4];
    int rx_pcts [4];
    logic [LEN_W-1:0] max_pick [4];
    int target;
    tx_pcts = '{0, 66, 0, 37};
    rx_pcts = '{0, 0, 66, 37};
    max_pick = '{16'hFFFF, 16'($urandom_range(300, 2)), 16'd1, 16'($urandom_range(64, 2))};
    for (int p = 0; p < 4; p++) begin
      set_config($urandom(), {16'($urandom()), max_pick[p]});
      tx_gap_pct = tx_pcts[p];
      rx_stall_pct <= rx_pcts[p];
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) send_random_frame();
    end
    tx_gap_pct = 0;
    rx_stall_pct <= 0;
  endtask

  task automatic test_backpressure();
    set_config($urandom(), 32'd16);
    rx_hold_on <= 1'b1;
    repeat (3) send_frame(cur_tag, 16'd8);
    rx_hold_on <= 1'b0;
  endtask

  task automatic test_longest_frame();
    set_config($urandom(), {16'($urandom()), 16'hFFFF});
    send_header(cur_tag, 16'hFFFF);
    repeat (32) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_hunt_basics();
    test_register_extremes();
    test_random_frames();
    test_backpressure();
    test_longest_frame();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/tlfd_pkg.sv
design/tlfd_hunter.sv
design/tlfd_body.sv
design/tagged_length_frame_deframer_core.sv
sim/tagged_length_frame_deframer_core_tb.sv
